// ----- src/usf_pkg.sv -----
// ----------------------------------------------------------------------------
// usf_pkg: shared types and helpers for the URL span finder
// Byte classes, queue entry layout, position width and output saturation.
// ----------------------------------------------------------------------------
package usf_pkg;

	// Width of the text position counter (8 to 32).
	localparam int POS_BITS = 16;
	// Width of the reported start and length fields.
	localparam int OUT_BITS = 16;

	// Decoupling queue between front and back.
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [OUT_BITS-1:0] out_t;

	// One classified byte as it travels from front to back.
	typedef struct packed {
		logic is_letter;
		logic is_url;
		logic is_colon;
		logic is_slash;
		logic last;
		pos_t pos;      // position of this byte
		pos_t end_pos;  // position + 1, saturated
	} beat_t;

	// Push side of the queue.
	typedef struct packed {
		logic  push;
		beat_t data;
	} q_wr_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	function automatic logic is_letter(input logic [7:0] c);
		logic r;
		case (c) inside
			[8'h41:8'h5A], [8'h61:8'h7A]: r = 1'b1;
			default:                      r = 1'b0;
		endcase
		return r;
	endfunction

	// Letters, digits and ~;/?:@=&$-_.+!*'(),
	function automatic logic is_url_char(input logic [7:0] c);
		logic r;
		case (c) inside
			[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h7E, 8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h3D,
			8'h26, 8'h24, 8'h2D, 8'h5F, 8'h2E, 8'h2B, 8'h21,
			8'h2A, 8'h27, 8'h28, 8'h29, 8'h2C: r = 1'b1;
			default:                           r = 1'b0;
		endcase
		return r;
	endfunction

	// Clamp a position-wide value to the output field width.
	function automatic out_t sat_out(input pos_t v);
		logic [POS_BITS+OUT_BITS-1:0] w;
		w = {{OUT_BITS{1'b0}}, v};
		if (w[POS_BITS+OUT_BITS-1:OUT_BITS] != '0)
			return {OUT_BITS{1'b1}};
		else
			return w[OUT_BITS-1:0];
	endfunction

endpackage

// ----- src/usf_front.sv -----
// ----------------------------------------------------------------------------
// usf_front: input side of the URL span finder
// Takes text bytes, classifies them and tags each with its text position.
// ----------------------------------------------------------------------------
module usf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     ch,
	input  logic           last,
	input  logic           q_full,
	output usf_pkg::q_wr_t q_wr
);

	usf_pkg::pos_t pos_q;
	logic          accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Position of the next byte; back to zero after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (last)
				pos_q <= '0;
			else if (pos_q != usf_pkg::POS_MAX)
				pos_q <= pos_q + usf_pkg::pos_t'(1);
		end
	end

	always_comb begin
		q_wr.push           = accept;
		q_wr.data.is_letter = usf_pkg::is_letter(ch);
		q_wr.data.is_url    = usf_pkg::is_url_char(ch);
		q_wr.data.is_colon  = (ch == usf_pkg::CH_COLON);
		q_wr.data.is_slash  = (ch == usf_pkg::CH_SLASH);
		q_wr.data.last      = last;
		q_wr.data.pos       = pos_q;
		q_wr.data.end_pos   = (pos_q == usf_pkg::POS_MAX) ? pos_q
		                                                  : pos_q + usf_pkg::pos_t'(1);
	end

endmodule

// ----- src/usf_fifo.sv -----
// ----------------------------------------------------------------------------
// usf_fifo: short queue between front and back
// Holds classified beats so either side can stall without the other.
// ----------------------------------------------------------------------------
module usf_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  usf_pkg::q_wr_t q_wr,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output usf_pkg::beat_t head
);

	usf_pkg::beat_t                    mem_q [usf_pkg::Q_DEPTH];
	logic [usf_pkg::Q_PTR_BITS-1:0]    wr_ptr_q;
	logic [usf_pkg::Q_PTR_BITS-1:0]    rd_ptr_q;
	logic [usf_pkg::Q_CNT_BITS-1:0]    cnt_q;

	localparam logic [usf_pkg::Q_PTR_BITS-1:0] PTR_LAST =
		usf_pkg::Q_PTR_BITS'(usf_pkg::Q_DEPTH - 1);
	localparam logic [usf_pkg::Q_CNT_BITS-1:0] CNT_FULL =
		usf_pkg::Q_CNT_BITS'(usf_pkg::Q_DEPTH);

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_wr.push)
			mem_q[wr_ptr_q] <= q_wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_wr.push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0
				            : wr_ptr_q + usf_pkg::Q_PTR_BITS'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0
				            : rd_ptr_q + usf_pkg::Q_PTR_BITS'(1);
			if (q_wr.push && !pop)
				cnt_q <= cnt_q + usf_pkg::Q_CNT_BITS'(1);
			else if (pop && !q_wr.push)
				cnt_q <= cnt_q - usf_pkg::Q_CNT_BITS'(1);
		end
	end

endmodule

// ----- src/usf_back.sv -----
// ----------------------------------------------------------------------------
// usf_back: scan state and result stage of the URL span finder
// Tracks letter runs and the "://" separator, opens and closes URLs.
// ----------------------------------------------------------------------------
module usf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  usf_pkg::beat_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output usf_pkg::out_t  url_start,
	output usf_pkg::out_t  url_length
);

	typedef enum logic [3:0] {
		SEP_NONE  = 4'b0001,
		SEP_COLON = 4'b0010,
		SEP_ONE   = 4'b0100,
		SEP_FULL  = 4'b1000
	} sep_t;

	sep_t          sep_q, sep_d;
	logic          prev_letter_q, prev_letter_d;
	logic          inside_q, inside_d;
	usf_pkg::pos_t run_start_q, run_start_d;
	usf_pkg::pos_t cand_q, cand_d;
	usf_pkg::pos_t open_q, open_d;

	logic          open_now, in_url, emit, out_free;
	usf_pkg::pos_t ustart, uend, ulen;

	usf_pkg::out_t start_q, length_q;
	logic          out_valid_q;

	assign open_now = !inside_q && (sep_q == SEP_FULL) && head.is_url;
	assign in_url   = inside_q || open_now;
	assign ustart   = open_now ? cand_q : open_q;
	assign emit     = in_url && (!head.is_url || head.last);
	// closing byte is excluded, a final URL byte is included
	assign uend     = head.is_url ? head.end_pos : head.pos;
	assign ulen     = (uend >= ustart) ? uend - ustart : '0;

	assign out_free = !out_valid_q || !out_stall;
	// beats that make no result pass even while a result waits
	assign pop      = !empty && (!emit || out_free);

	always_comb begin
		sep_d         = sep_q;
		prev_letter_d = prev_letter_q;
		inside_d      = inside_q;
		run_start_d   = run_start_q;
		cand_d        = cand_q;
		open_d        = open_q;
		if (head.last) begin
			sep_d         = SEP_NONE;
			prev_letter_d = 1'b0;
			inside_d      = 1'b0;
			run_start_d   = '0;
			cand_d        = '0;
			open_d        = '0;
		end else if (in_url && !emit) begin
			inside_d      = 1'b1;
			open_d        = ustart;
			sep_d         = SEP_NONE;
			prev_letter_d = 1'b0;
		end else begin
			inside_d = 1'b0;
			if (head.is_colon) begin
				if (prev_letter_q) begin
					sep_d  = SEP_COLON;
					cand_d = run_start_q;
				end else begin
					sep_d = SEP_NONE;
				end
			end else if (head.is_slash && sep_q == SEP_COLON) begin
				sep_d = SEP_ONE;
			end else if (head.is_slash && sep_q == SEP_ONE) begin
				sep_d = SEP_FULL;
			end else begin
				sep_d = SEP_NONE;
			end
			if (head.is_letter) begin
				if (!prev_letter_q)
					run_start_d = head.pos;
				prev_letter_d = 1'b1;
			end else begin
				prev_letter_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q         <= SEP_NONE;
			prev_letter_q <= 1'b0;
			inside_q      <= 1'b0;
			run_start_q   <= '0;
			cand_q        <= '0;
			open_q        <= '0;
		end else if (pop) begin
			sep_q         <= sep_d;
			prev_letter_q <= prev_letter_d;
			inside_q      <= inside_d;
			run_start_q   <= run_start_d;
			cand_q        <= cand_d;
			open_q        <= open_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			start_q  <= usf_pkg::sat_out(ustart);
			length_q <= usf_pkg::sat_out(ulen);
		end
	end

	assign out_valid  = out_valid_q;
	assign url_start  = start_q;
	assign url_length = length_q;

endmodule

// ----- src/url_span_finder.sv -----
// ----------------------------------------------------------------------------
// url_span_finder: streaming URL locator
// Finds "letters://url-chars" spans in a byte stream, reports start and length.
// ----------------------------------------------------------------------------
// Text comes in one byte per beat, last set on the final byte of a text;
// positions restart at zero after it. A URL opens at the first letter of the
// letter run just before "://" when the byte after the separator is a URL
// character (letters, digits, ~;/?:@=&$-_.+!*'(),), and closes at the first
// other byte (not included) or at the final byte (included). Each URL gives
// one output beat of url_start and url_length, both clamped to 65535;
// positions saturate at 2^POS_BITS-1. The block takes one byte every cycle
// while the queue is not full. The front classifies a byte and tags its
// position as it is accepted, a two-entry queue follows, and the back
// updates the scan state for one byte per cycle unless held as below; a
// result is registered when the back takes the byte that closed it. Only
// the single output register can hold the back: while a result waits there,
// bytes that close nothing keep flowing, and the next closing byte waits at
// the queue head; in_stall rises when the queue is full.
// ----------------------------------------------------------------------------
module url_span_finder (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        last,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] url_start,
	output logic [15:0] url_length
);

	usf_pkg::q_wr_t q_wr;
	usf_pkg::beat_t q_head;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;

	// classify and tag bytes
	usf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ch       (ch),
		.last     (last),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	// decoupling queue
	usf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	// scan state and result register
	usf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.url_start  (url_start),
		.url_length (url_length)
	);

	// queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_wr.push)
		else $error("queue push while full");

	// queue never read while empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_pop)
		else $error("queue pop while empty");

	// a new result beat only follows a beat taken from the queue
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_pop))
		else $error("result without a consumed beat");

	// back never idles with work queued and a free result register
	a_back_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && !out_valid) |-> q_pop)
		else $error("back stalled without cause");

endmodule
